### hdl/assert_macros.svh
// assertion macros for the sensor temperature polynomial block
// clocked on i_clk; the first form is disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define STP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define STP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/stp_pkg.sv
// stp_pkg: widths, register codes, scale constants and stage data types
// shared by all modules of the sensor temperature polynomial block
package stp_pkg;

    localparam int RAW_W        = 24;
    localparam int A_W          = 16;
    localparam int COEF_W       = 16;
    localparam int NUM_REGS     = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int ACC_W        = 88;
    localparam int HALF_W       = ACC_W / 2;
    localparam int LO_P_W       = HALF_W + A_W;
    localparam int SCALE_W      = 64;
    localparam int HALF_SCALE_W = SCALE_W / 2;
    localparam int PART_W       = COEF_W + HALF_SCALE_W;
    localparam int SCALED_W     = COEF_W + SCALE_W;
    localparam int NUM_CELLS    = 4;
    localparam int Q_W          = 10;
    localparam int OUT_W        = 9;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_COEF_QUARTIC = 3'd0;
    localparam t_reg_idx REG_COEF_CUBIC   = 3'd1;
    localparam t_reg_idx REG_COEF_SQUARE  = 3'd2;
    localparam t_reg_idx REG_COEF_LINEAR  = 3'd3;
    localparam t_reg_idx REG_COEF_OFFSET  = 3'd4;

    // addend scale per horner cell: cubic, square, linear, offset
    localparam logic [SCALE_W-1:0] HORNER_SCALE [NUM_CELLS] = '{
        64'd400000,
        64'd20000000000,
        64'd1000000000000000,
        64'd15000000000000000000
    };
    // cells whose addend is subtracted
    localparam logic [NUM_CELLS-1:0] HORNER_SUB = 4'b1010;

    localparam logic [ACC_W-1:0] DIVISOR = 88'd1000000000000000000000;

    localparam logic [Q_W-1:0]   NEG_LIMIT = 10'd256;
    localparam logic [Q_W-1:0]   POS_LIMIT = 10'd255;
    localparam logic [OUT_W-1:0] OUT_MIN   = 9'h100;
    localparam logic [OUT_W-1:0] OUT_MAX   = 9'h0ff;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [A_W-1:0]   a;
    } t_horner_data;

    typedef struct packed {
        logic [ACC_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
    } t_div_data;

endpackage

### hdl/stp_coef_scale.sv
// stp_coef_scale: coefficient times a 64-bit scale constant, two register stages
// depends on stp_pkg
module stp_coef_scale (
    input  logic                          i_clk,
    input  logic [stp_pkg::COEF_W-1:0]    i_coef,
    input  logic [stp_pkg::SCALE_W-1:0]   i_scale,
    output logic [stp_pkg::SCALED_W-1:0]  o_scaled
);

    logic [stp_pkg::PART_W-1:0]   r_lo_p;
    logic [stp_pkg::PART_W-1:0]   r_hi_p;
    logic [stp_pkg::SCALED_W-1:0] r_scaled;
    logic [stp_pkg::PART_W-1:0]   n_lo_p;
    logic [stp_pkg::PART_W-1:0]   n_hi_p;
    logic [stp_pkg::SCALED_W-1:0] n_scaled;

    always_comb begin
        n_lo_p   = stp_pkg::PART_W'(i_coef)
                 * stp_pkg::PART_W'(i_scale[stp_pkg::HALF_SCALE_W-1:0]);
        n_hi_p   = stp_pkg::PART_W'(i_coef)
                 * stp_pkg::PART_W'(i_scale[stp_pkg::SCALE_W-1:stp_pkg::HALF_SCALE_W]);
        n_scaled = {r_hi_p, {stp_pkg::HALF_SCALE_W{1'b0}}} + stp_pkg::SCALED_W'(r_lo_p);
    end

    always_ff @(posedge i_clk) begin
        r_lo_p   <= n_lo_p;
        r_hi_p   <= n_hi_p;
        r_scaled <= n_scaled;
    end

    assign o_scaled = r_scaled;

endmodule

### hdl/stp_horner_cell.sv
// stp_horner_cell: one horner step, acc * a plus or minus a scaled coefficient
// multiply stage and combine stage with valid/ready; depends on stp_pkg
module stp_horner_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  stp_pkg::t_horner_data       i_data,
    input  logic [stp_pkg::ACC_W-1:0]   i_addend,
    input  logic                        i_sub,
    output logic                        o_valid,
    input  logic                        i_ready,
    output stp_pkg::t_horner_data       o_data
);

    logic                        r_m_valid;
    logic [stp_pkg::LO_P_W-1:0]  r_m_lo;
    logic [stp_pkg::HALF_W-1:0]  r_m_hi;
    logic [stp_pkg::A_W-1:0]     r_m_a;
    logic                        r_c_valid;
    stp_pkg::t_horner_data       r_c_data;

    logic [stp_pkg::LO_P_W-1:0]  n_m_lo;
    logic [stp_pkg::HALF_W-1:0]  n_m_hi;
    logic [stp_pkg::ACC_W-1:0]   n_base;
    stp_pkg::t_horner_data       n_c_data;
    logic                        w_ready_m;
    logic                        w_ready_c;

    assign w_ready_c = !r_c_valid || i_ready;
    assign w_ready_m = !r_m_valid || w_ready_c;

    always_comb begin
        // the high half only counts modulo 2^HALF_W once shifted up
        n_m_lo = stp_pkg::LO_P_W'(i_data.acc[stp_pkg::HALF_W-1:0])
               * stp_pkg::LO_P_W'(i_data.a);
        n_m_hi = i_data.acc[stp_pkg::ACC_W-1:stp_pkg::HALF_W]
               * stp_pkg::HALF_W'(i_data.a);
        n_base = {r_m_hi, {stp_pkg::HALF_W{1'b0}}} + stp_pkg::ACC_W'(r_m_lo);
        n_c_data.acc = i_sub ? (n_base - i_addend) : (n_base + i_addend);
        n_c_data.a   = r_m_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_ready_m) begin
                r_m_valid <= i_valid;
            end
            if (w_ready_c) begin
                r_c_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_m) begin
            r_m_lo <= n_m_lo;
            r_m_hi <= n_m_hi;
            r_m_a  <= i_data.a;
        end
        if (w_ready_c) begin
            r_c_data <= n_c_data;
        end
    end

    assign o_ready = w_ready_m;
    assign o_valid = r_c_valid;
    assign o_data  = r_c_data;

endmodule

### hdl/stp_div_cell.sv
// stp_div_cell: one restoring division step against a shifted divisor
// valid/ready stage; depends on stp_pkg
module stp_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  stp_pkg::t_div_data          i_data,
    input  logic [stp_pkg::ACC_W-1:0]   i_divisor,
    output logic                        o_valid,
    input  logic                        i_ready,
    output stp_pkg::t_div_data          o_data
);

    logic                r_valid;
    stp_pkg::t_div_data  r_data;
    stp_pkg::t_div_data  n_data;
    logic                w_ready;
    logic                w_bit;

    assign w_ready = !r_valid || i_ready;

    always_comb begin
        w_bit      = (i_data.rem >= i_divisor);
        n_data.rem = w_bit ? (i_data.rem - i_divisor) : i_data.rem;
        n_data.q   = {i_data.q[stp_pkg::Q_W-2:0], w_bit};
        n_data.neg = i_data.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready) begin
            r_data <= n_data;
        end
    end

    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hdl/sensor_temperature_polynomial.sv
// sensor_temperature_polynomial: top level, raw reading to whole degrees
// depends on stp_pkg, stp_coef_scale, stp_horner_cell, stp_div_cell, assert_macros.svh
//
// input channel: i_valid / o_stall with i_raw_reading; a request is taken at an
// edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with o_temperature_deg and o_clipped
// config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
// quartic, cubic, square, linear, offset (0..4); other indexes are ignored
// throughput: one request per cycle while o_stall is low
// path: an accepted request passes the chain of four two-stage horner cells, one
// magnitude stage, ten division cells and the output register, which raises o_valid
// coefficient writes reach the datapath through the registered scaling pipeline
// reset clears all coefficients to zero and empties every stage
// a stalled result holds in the output register while bubbles in the chain
// still fill; o_stall rises only once every stage holds a request
`include "assert_macros.svh"

module sensor_temperature_polynomial (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [stp_pkg::RAW_W-1:0]             i_raw_reading,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [stp_pkg::OUT_W-1:0]      o_temperature_deg,
    output logic                                  o_clipped,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [stp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [stp_pkg::COEF_W-1:0]            i_cfg_data
);

    logic [stp_pkg::COEF_W-1:0]    r_coef [stp_pkg::NUM_REGS];
    logic [stp_pkg::SCALED_W-1:0]  w_scaled [stp_pkg::NUM_CELLS];

    stp_pkg::t_horner_data         w_h_data [stp_pkg::NUM_CELLS+1];
    logic [stp_pkg::NUM_CELLS:0]   w_h_valid;
    logic [stp_pkg::NUM_CELLS:0]   w_h_ready;

    logic                          r_abs_valid;
    logic [stp_pkg::ACC_W-1:0]     r_abs_mag;
    logic                          r_abs_neg;
    logic [stp_pkg::ACC_W-1:0]     n_abs_mag;
    logic                          n_abs_neg;

    stp_pkg::t_div_data            w_d_data [stp_pkg::Q_W+1];
    logic [stp_pkg::Q_W:0]         w_d_valid;
    logic [stp_pkg::Q_W:0]         w_d_ready;

    logic                          r_out_valid;
    logic [stp_pkg::OUT_W-1:0]     r_out_temp;
    logic                          r_out_clip;
    logic [stp_pkg::OUT_W-1:0]     n_out_temp;
    logic                          n_out_clip;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < stp_pkg::NUM_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                stp_pkg::REG_COEF_QUARTIC: r_coef[stp_pkg::REG_COEF_QUARTIC] <= i_cfg_data;
                stp_pkg::REG_COEF_CUBIC:   r_coef[stp_pkg::REG_COEF_CUBIC]   <= i_cfg_data;
                stp_pkg::REG_COEF_SQUARE:  r_coef[stp_pkg::REG_COEF_SQUARE]  <= i_cfg_data;
                stp_pkg::REG_COEF_LINEAR:  r_coef[stp_pkg::REG_COEF_LINEAR]  <= i_cfg_data;
                stp_pkg::REG_COEF_OFFSET:  r_coef[stp_pkg::REG_COEF_OFFSET]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // horner chain, seeded with -2 * quartic
    assign w_h_data[0].acc = stp_pkg::ACC_W'(0)
                           - stp_pkg::ACC_W'({r_coef[stp_pkg::REG_COEF_QUARTIC], 1'b0});
    assign w_h_data[0].a   = i_raw_reading[stp_pkg::RAW_W-1 -: stp_pkg::A_W];
    assign w_h_valid[0]    = i_valid;
    assign o_stall         = !w_h_ready[0];

    for (genvar g = 0; g < stp_pkg::NUM_CELLS; g++) begin : g_horner
        stp_coef_scale u_scale (
            .i_clk    (i_clk),
            .i_coef   (r_coef[g+1]),
            .i_scale  (stp_pkg::HORNER_SCALE[g]),
            .o_scaled (w_scaled[g])
        );

        stp_horner_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (w_h_valid[g]),
            .o_ready  (w_h_ready[g]),
            .i_data   (w_h_data[g]),
            .i_addend (stp_pkg::ACC_W'(w_scaled[g])),
            .i_sub    (stp_pkg::HORNER_SUB[g]),
            .o_valid  (w_h_valid[g+1]),
            .i_ready  (w_h_ready[g+1]),
            .o_data   (w_h_data[g+1])
        );
    end

    // sign and magnitude
    assign w_h_ready[stp_pkg::NUM_CELLS] = !r_abs_valid || w_d_ready[0];

    always_comb begin
        n_abs_neg = w_h_data[stp_pkg::NUM_CELLS].acc[stp_pkg::ACC_W-1];
        n_abs_mag = n_abs_neg ? (stp_pkg::ACC_W'(0) - w_h_data[stp_pkg::NUM_CELLS].acc)
                              : w_h_data[stp_pkg::NUM_CELLS].acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abs_valid <= 1'b0;
        end else if (w_h_ready[stp_pkg::NUM_CELLS]) begin
            r_abs_valid <= w_h_valid[stp_pkg::NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_h_ready[stp_pkg::NUM_CELLS]) begin
            r_abs_mag <= n_abs_mag;
            r_abs_neg <= n_abs_neg;
        end
    end

    // division chain, quotient msb first
    assign w_d_data[0].rem = r_abs_mag;
    assign w_d_data[0].q   = '0;
    assign w_d_data[0].neg = r_abs_neg;
    assign w_d_valid[0]    = r_abs_valid;

    for (genvar g = 0; g < stp_pkg::Q_W; g++) begin : g_div
        stp_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_d_valid[g]),
            .o_ready   (w_d_ready[g]),
            .i_data    (w_d_data[g]),
            .i_divisor (stp_pkg::DIVISOR << (stp_pkg::Q_W - 1 - g)),
            .o_valid   (w_d_valid[g+1]),
            .i_ready   (w_d_ready[g+1]),
            .o_data    (w_d_data[g+1])
        );
    end

    // saturation and output register
    assign w_d_ready[stp_pkg::Q_W] = !r_out_valid || !i_stall;

    always_comb begin
        if (w_d_data[stp_pkg::Q_W].neg) begin
            if (w_d_data[stp_pkg::Q_W].q > stp_pkg::NEG_LIMIT) begin
                n_out_temp = stp_pkg::OUT_MIN;
                n_out_clip = 1'b1;
            end else begin
                n_out_temp = stp_pkg::OUT_W'(stp_pkg::Q_W'(0) - w_d_data[stp_pkg::Q_W].q);
                n_out_clip = 1'b0;
            end
        end else begin
            if (w_d_data[stp_pkg::Q_W].q > stp_pkg::POS_LIMIT) begin
                n_out_temp = stp_pkg::OUT_MAX;
                n_out_clip = 1'b1;
            end else begin
                n_out_temp = w_d_data[stp_pkg::Q_W].q[stp_pkg::OUT_W-1:0];
                n_out_clip = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_d_ready[stp_pkg::Q_W]) begin
            r_out_valid <= w_d_valid[stp_pkg::Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ready[stp_pkg::Q_W]) begin
            r_out_temp <= n_out_temp;
            r_out_clip <= n_out_clip;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_temperature_deg = r_out_temp;
    assign o_clipped         = r_out_clip;

    `STP_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_valid, "output valid after reset")
    `STP_ASSERT(a_stall_only_full, o_stall |-> ((&w_h_valid[stp_pkg::NUM_CELLS:1]) && (&w_d_valid) && r_abs_valid && r_out_valid), "input stalled with a free stage")
    `STP_ASSERT(a_clip_saturates, (o_valid && o_clipped) |-> (r_out_temp == stp_pkg::OUT_MAX || r_out_temp == stp_pkg::OUT_MIN), "clipped result not at a limit")

endmodule
